### sv/tile_height_ramp_sampler_defines.svh
// assertion macros used by the sampler core
`ifndef TILE_HEIGHT_RAMP_SAMPLER_DEFINES_SVH
`define TILE_HEIGHT_RAMP_SAMPLER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define THRS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define THRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/thrs_pkg.sv
// shared types and constants of the tile height ramp sampler
package thrs_pkg;

	typedef enum logic [1:0] {
		KIND_CELL  = 2'd0,
		KIND_RAMP  = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		HEAD_NORTH = 2'd0,
		HEAD_EAST  = 2'd1,
		HEAD_SOUTH = 2'd2,
		HEAD_WEST  = 2'd3
	} heading_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [15:0]        cell_index;
		logic signed [31:0] cell_height;
		logic [3:0]         ramp_slot;
		logic signed [15:0] ramp_col;
		logic signed [15:0] ramp_row;
		logic [1:0]         ramp_heading;
		logic signed [31:0] ramp_bottom;
		logic signed [31:0] ramp_top;
		logic signed [31:0] query_x;
		logic signed [31:0] query_z;
	} in_word_t;

	typedef struct packed {
		logic               inside_grid;
		logic signed [31:0] surface_height;
		logic               on_ramp;
		logic [3:0]         ramp_hit;
	} out_word_t;

	// configuration register indexes
	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd1;
	localparam logic [2:0] REG_COLUMNS  = 3'd2;
	localparam logic [2:0] REG_ROWS     = 3'd3;
	localparam logic [2:0] REG_SPAN     = 3'd4;
	localparam logic [2:0] REG_RAMPS    = 3'd5;

	localparam logic [30:0] SPAN_ONE = 31'd65536;

	typedef struct packed {
		logic signed [15:0] base_col;
		logic signed [15:0] base_row;
		logic [8:0]         columns;
		logic [8:0]         rows;
		logic [30:0]        span;
		logic [4:0]         ramps;
	} cfg_t;

	// divider request and answer between the sequencer and divider
	typedef struct packed {
		logic               start;
		logic signed [63:0] num;
		logic [30:0]        den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [32:0] quo;
		logic [15:0]        frac;
	} div_rsp_t;

endpackage

### sv/thrs_regs.sv
// configuration register file with apb-style access
module thrs_regs (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [4:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	output thrs_pkg::cfg_t cfg
);
	import thrs_pkg::*;

	cfg_t        cfg_q;
	logic [2:0]  idx;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_col <= '0;
			cfg_q.base_row <= '0;
			cfg_q.columns  <= '0;
			cfg_q.rows     <= '0;
			cfg_q.span     <= SPAN_ONE;
			cfg_q.ramps    <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_ORIGIN_X: cfg_q.base_col <= pwdata[15:0];
				REG_ORIGIN_Z: cfg_q.base_row <= pwdata[15:0];
				REG_COLUMNS:  cfg_q.columns  <= pwdata[8:0];
				REG_ROWS:     cfg_q.rows     <= pwdata[8:0];
				REG_SPAN:     cfg_q.span     <= pwdata[30:0];
				REG_RAMPS:    cfg_q.ramps    <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_ORIGIN_X: prdata = {{16{cfg_q.base_col[15]}}, cfg_q.base_col};
			REG_ORIGIN_Z: prdata = {{16{cfg_q.base_row[15]}}, cfg_q.base_row};
			REG_COLUMNS:  prdata = {23'd0, cfg_q.columns};
			REG_ROWS:     prdata = {23'd0, cfg_q.rows};
			REG_SPAN:     prdata = {1'b0, cfg_q.span};
			REG_RAMPS:    prdata = {27'd0, cfg_q.ramps};
			default:      prdata = '0;
		endcase
	end
endmodule

### sv/thrs_divider.sv
// restoring divider: floor tile index and 16 bit fraction, one bit a cycle
module thrs_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  thrs_pkg::div_req_t req,
	output thrs_pkg::div_rsp_t rsp
);
	import thrs_pkg::*;

	// the dividend is shifted left 16 so one pass yields index and fraction
	localparam int NBITS = 82;

	logic [81:0] num_q;
	logic [31:0] rem_q;
	logic [30:0] den_q;
	logic        neg_q;
	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [81:0] quo_q;
	logic [32:0] trial;
	logic [63:0] mag;
	logic [81:0] qadj;

	assign mag   = req.num[63] ? 64'(-req.num) : 64'(req.num);
	assign trial = {rem_q, num_q[81]} - {2'b0, den_q};

	// floor for negatives: -(q+1) when a remainder is left, else -q,
	// done on the joint Q.16 quotient: floor(-m/den) on the shifted value
	assign qadj  = neg_q ? (~quo_q + 82'(rem_q == 0)) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(NBITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= {2'b0, mag, 16'd0};
			rem_q <= '0;
			den_q <= req.den;
			neg_q <= req.num[63];
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[80:0], 1'b0};
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[80:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], num_q[81]};
				quo_q <= {quo_q[80:0], 1'b0};
			end
		end
	end

	// floor((d<<16)/s): high part is floor(d/s), low 16 bits the fraction
	assign rsp.done = done_q;
	assign rsp.quo  = qadj[48:16];
	assign rsp.frac = qadj[15:0];
endmodule

### sv/thrs_core.sv
// query sequencer with grid and ramp memories
module thrs_core #(
	parameter int GRID_CELLS = 65536,
	parameter int RAMP_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  thrs_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  thrs_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output thrs_pkg::out_word_t out_data,
	output thrs_pkg::div_req_t  div_req,
	input  thrs_pkg::div_rsp_t  div_rsp
);
	import thrs_pkg::*;

	localparam int GW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
	localparam int RW = (RAMP_SLOTS > 1) ? $clog2(RAMP_SLOTS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIVX, ST_DIVZ, ST_CHECK, ST_ADDR, ST_READ, ST_GRID,
		ST_SCAN, ST_MUL, ST_SCALE, ST_OUT
	} state_t;

	typedef struct packed {
		logic signed [15:0] row;
		logic signed [15:0] col;
		logic [1:0]         heading;
		logic signed [31:0] bottom;
		logic signed [31:0] top;
	} ramp_t;

	logic [31:0] grid_mem [GRID_CELLS];
	ramp_t       ramp_mem [RAMP_SLOTS];

	state_t             state_q;
	logic               busy_q;
	logic signed [31:0] qz_q;
	logic [30:0]        span_q;
	logic signed [32:0] tx_q, tz_q;
	logic [15:0]        fx_q, fz_q;
	logic [GW-1:0]      gaddr_q;
	logic [31:0]        grid_rd_q;
	ramp_t              ramp_rd_q;
	logic [RW:0]        slot_q;
	logic [RW:0]        limit_q;
	logic signed [32:0] diff_q;
	logic [16:0]        t_q;
	logic signed [50:0] prod_q;
	logic [RW-1:0]      hit_q;
	out_word_t          out_q;
	logic               out_valid_q;
	logic signed [31:0] lo_q;
	logic [17:0]        rowmul_q;

	logic               take;
	logic signed [63:0] orig_z;
	logic signed [16:0] abs_col, abs_row;
	logic               in_grid;
	logic               match;

	assign take     = in_valid && !in_stall;
	assign in_stall = busy_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign orig_z = 64'(cfg.base_row) * 64'(signed'({1'b0, span_q}));

	assign in_grid = (cfg.columns != 0) && (cfg.rows != 0) && !tx_q[32] && !tz_q[32] &&
		(tx_q < 33'(signed'({1'b0, cfg.columns}))) && (tz_q < 33'(signed'({1'b0, cfg.rows})));

	// absolute tile compared at full width so no wrap can match
	assign abs_col = 17'(tx_q) + 17'(cfg.base_col);
	assign abs_row = 17'(tz_q) + 17'(cfg.base_row);
	assign match   = (17'(ramp_rd_q.col) == abs_col) && (17'(ramp_rd_q.row) == abs_row);

	// memory writes from load words
	always_ff @(posedge clk) begin
		if (take && kind_t'(in_data.kind) == KIND_CELL && 32'(in_data.cell_index) < GRID_CELLS)
			grid_mem[GW'(in_data.cell_index)] <= in_data.cell_height;
		if (take && kind_t'(in_data.kind) == KIND_RAMP && 32'(in_data.ramp_slot) < RAMP_SLOTS)
			ramp_mem[RW'(in_data.ramp_slot)] <= '{in_data.ramp_row, in_data.ramp_col,
				in_data.ramp_heading, in_data.ramp_bottom, in_data.ramp_top};
		grid_rd_q <= grid_mem[gaddr_q];
		ramp_rd_q <= ramp_mem[slot_q[RW-1:0]];
	end

	// divider request
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = span_q;
		if (state_q == ST_IDLE && take && kind_t'(in_data.kind) == KIND_QUERY) begin
			div_req.start = 1'b1;
			div_req.den   = (cfg.span == 0) ? SPAN_ONE : cfg.span;
			div_req.num   = 64'(in_data.query_x) -
				64'(cfg.base_col) * 64'(signed'({1'b0, div_req.den}));
		end else if (state_q == ST_DIVX && div_rsp.done) begin
			div_req.start = 1'b1;
			div_req.num   = 64'(qz_q) - orig_z;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take && kind_t'(in_data.kind) == KIND_QUERY) begin
						state_q <= ST_DIVX;
						busy_q  <= 1'b1;
					end
				end
				ST_DIVX: if (div_rsp.done) state_q <= ST_DIVZ;
				ST_DIVZ: if (div_rsp.done) state_q <= ST_CHECK;
				ST_CHECK: begin
					// wait here while the previous result is still held
					if (!out_valid_q) begin
						if (!in_grid) begin
							out_q   <= '0;
							state_q <= ST_OUT;
						end else
							state_q <= ST_ADDR;
					end
				end
				ST_ADDR:  state_q <= ST_READ;
				ST_READ:  state_q <= ST_GRID;
				ST_GRID: begin
					state_q <= (slot_q < limit_q) ? ST_SCAN : ST_OUT;
					out_q   <= '{1'b1, grid_rd_q, 1'b0, 4'd0};
				end
				ST_SCAN: begin
					if (match) state_q <= ST_MUL;
					else if (slot_q + 1'b1 < limit_q) state_q <= ST_GRID;
					else state_q <= ST_OUT;
				end
				ST_MUL:   state_q <= ST_SCALE;
				ST_SCALE: begin
					out_q   <= '{1'b1, lo_q + 32'(prod_q >>> 16), 1'b1, 4'(hit_q)};
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				qz_q    <= in_data.query_z;
				span_q  <= (cfg.span == 0) ? SPAN_ONE : cfg.span;
				slot_q  <= '0;
				limit_q <= (32'(cfg.ramps) > RAMP_SLOTS) ? (RW+1)'(RAMP_SLOTS) : (RW+1)'(cfg.ramps);
			end
			ST_DIVX: if (div_rsp.done) begin tx_q <= div_rsp.quo; fx_q <= div_rsp.frac; end
			ST_DIVZ: if (div_rsp.done) begin tz_q <= div_rsp.quo; fz_q <= div_rsp.frac; end
			ST_CHECK: rowmul_q <= 18'(tz_q[8:0]) * 18'(cfg.columns);
			ST_ADDR:  gaddr_q  <= GW'(rowmul_q + 18'(tx_q[8:0]));
			ST_GRID:  ;
			ST_SCAN: begin
				if (match) begin
					hit_q <= slot_q[RW-1:0];
					lo_q  <= ramp_rd_q.bottom;
					diff_q <= 33'(ramp_rd_q.top) - 33'(ramp_rd_q.bottom);
					unique case (heading_t'(ramp_rd_q.heading))
						HEAD_NORTH: t_q <= 17'h10000 - 17'(fz_q);
						HEAD_EAST:  t_q <= 17'(fx_q);
						HEAD_SOUTH: t_q <= 17'(fz_q);
						HEAD_WEST:  t_q <= 17'h10000 - 17'(fx_q);
						default:    t_q <= '0;
					endcase
				end else
					slot_q <= slot_q + 1'b1;
			end
			ST_MUL: prod_q <= 51'(diff_q) * 51'(signed'({1'b0, t_q}));
			default: ;
		endcase
	end

	`include "tile_height_ramp_sampler_defines.svh"

	`THRS_ASSERT_IMP(a_busy_stalls, state_q != ST_IDLE, in_stall, "input not stalled while busy")
	`THRS_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(out_data), "result lost")
	`THRS_ASSERT_IMP(a_ramp_inside, out_valid && out_data.on_ramp, out_data.inside_grid, "ramp outside grid")
	`THRS_ASSERT_IMP(a_div_idle, div_req.start, state_q == ST_IDLE || state_q == ST_DIVX, "divider started late")
endmodule

### sv/tile_height_ramp_sampler.sv
// top level of the tile height ramp sampler
//
// channel  direction  payload
// in       input      in_word_t: load cell, load ramp or query
// out      output     out_word_t: one word per query
// apb      input      six configuration registers at 4*i
//
// loads are written when accepted and leave the block idle; a query result is
// registered after two 82-step bit-serial divisions when outside the grid; inside
// it the grid cell is then read and the ramp slots searched in order, a hit adding
// a multiply and a scale step; a query waits before its result stage while the
// previous word is still stalled; input stalls until its result is registered
// reset initialises control and settings; memories are undefined until loaded
module tile_height_ramp_sampler #(
	parameter int GRID_CELLS = 65536,
	parameter int RAMP_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  thrs_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output thrs_pkg::out_word_t out_data
);
	import thrs_pkg::*;

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	thrs_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	thrs_divider u_div (.clk, .arst_n, .req(div_req), .rsp(div_rsp));

	thrs_core #(.GRID_CELLS(GRID_CELLS), .RAMP_SLOTS(RAMP_SLOTS)) u_core (
		.clk, .arst_n, .cfg, .in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data, .div_req, .div_rsp
	);
endmodule

### tb/tile_height_ramp_sampler_check.sv
// checker for the tile height ramp sampler: mirrors registers, predicts and compares
module tile_height_ramp_sampler_check
	import thrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_word_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_word_t   out_data,
	output int          failures,
	output int          pending,
	output int          checked,
	output int          ramp_results
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint FRAC_ONE = 65536;

	// mirrored configuration
	logic signed [15:0] org_x, org_z;
	logic [8:0]         n_cols, n_rows;
	logic [30:0]        span_reg;
	logic [4:0]         n_ramps;

	// mirrored tables
	logic [31:0]        ground [65536];
	logic signed [15:0] slope_col [16];
	logic signed [15:0] slope_row [16];
	logic [1:0]         slope_head [16];
	logic signed [31:0] slope_low [16];
	logic signed [31:0] slope_high [16];

	out_word_t heights_due [$];

	// split one coordinate into tile index and Q0.16 fraction
	function automatic void split_coord(input longint q, input longint org, input longint sp,
			output longint tile, output longint frac);
		longint d;
		d = q - org * sp;
		tile = d / sp;
		if ((d % sp) != 0 && d < 0)
			tile = tile - 1;
		frac = ((d - tile * sp) <<< 16) / sp;
	endfunction

	// surface height seen by one query
	function automatic out_word_t sample_surface(input in_word_t w);
		out_word_t r;
		longint sp, tx, tz, fx, fz, y, t, lo, hi;
		int lim;
		r = '0;
		sp = (span_reg == 0) ? FRAC_ONE : longint'(span_reg);
		split_coord(longint'(w.query_x), longint'(org_x), sp, tx, fx);
		split_coord(longint'(w.query_z), longint'(org_z), sp, tz, fz);
		if (n_cols == 0 || n_rows == 0 || tx < 0 || tz < 0 ||
				tx >= longint'(n_cols) || tz >= longint'(n_rows))
			return r;
		y = longint'($signed(ground[(tz * n_cols + tx) % 65536]));
		lim = (n_ramps > 16) ? 16 : int'(n_ramps);
		for (int s = 0; s < lim; s++) begin
			if (longint'(slope_col[s]) == tx + org_x && longint'(slope_row[s]) == tz + org_z) begin
				case (heading_t'(slope_head[s]))
					HEAD_NORTH: t = FRAC_ONE - fz;
					HEAD_EAST:  t = fx;
					HEAD_SOUTH: t = fz;
					default:    t = FRAC_ONE - fx;
				endcase
				lo = longint'(slope_low[s]);
				hi = longint'(slope_high[s]);
				y = lo + (((hi - lo) * t) >>> 16);
				r.on_ramp = 1'b1;
				r.ramp_hit = 4'(s);
				break;
			end
		end
		r.inside_grid = 1'b1;
		r.surface_height = 32'(y);
		return r;
	endfunction

	// register writes, loads, predictions and comparisons
	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			org_x <= '0;
			org_z <= '0;
			n_cols <= '0;
			n_rows <= '0;
			span_reg <= SPAN_ONE;
			n_ramps <= '0;
			failures = 0;
			pending = 0;
			checked = 0;
			ramp_results = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_ORIGIN_X: org_x <= pwdata[15:0];
					REG_ORIGIN_Z: org_z <= pwdata[15:0];
					REG_COLUMNS:  n_cols <= pwdata[8:0];
					REG_ROWS:     n_rows <= pwdata[8:0];
					REG_SPAN:     span_reg <= pwdata[30:0];
					REG_RAMPS:    n_ramps <= pwdata[4:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				case (kind_t'(in_data.kind))
					KIND_CELL: ground[in_data.cell_index] = in_data.cell_height;
					KIND_RAMP: begin
						slope_col[in_data.ramp_slot] = in_data.ramp_col;
						slope_row[in_data.ramp_slot] = in_data.ramp_row;
						slope_head[in_data.ramp_slot] = in_data.ramp_heading;
						slope_low[in_data.ramp_slot] = in_data.ramp_bottom;
						slope_high[in_data.ramp_slot] = in_data.ramp_top;
					end
					KIND_QUERY: heights_due = {heights_due, sample_surface(in_data)};
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (heights_due.size() == 0) begin
					$error("result word with nothing expected");
					failures++;
				end else begin
					e = heights_due.pop_front();
					checked++;
					if (e.on_ramp)
						ramp_results++;
					if (out_data.inside_grid !== e.inside_grid) begin
						$error("inside_grid expected %0d got %0d", e.inside_grid,
							out_data.inside_grid);
						failures++;
					end
					if (out_data.surface_height !== e.surface_height) begin
						$error("surface_height expected %0d got %0d", e.surface_height,
							out_data.surface_height);
						failures++;
					end
					if (out_data.on_ramp !== e.on_ramp) begin
						$error("on_ramp expected %0d got %0d", e.on_ramp, out_data.on_ramp);
						failures++;
					end
					if (out_data.ramp_hit !== e.ramp_hit) begin
						$error("ramp_hit expected %0d got %0d", e.ramp_hit, out_data.ramp_hit);
						failures++;
					end
				end
			end
			pending = heights_due.size();
		end
	end

endmodule

### tb/tile_height_ramp_sampler_test.sv
// stimulus and verdict for the tile height ramp sampler
module tile_height_ramp_sampler_test;
	import thrs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk, arst_n;
	logic        psel, penable, pwrite, pready;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        in_valid, in_stall, out_valid, out_stall;
	in_word_t    in_data;
	out_word_t   out_data;
	int          failures, pending, checked, ramp_results;

	int send_idle, recv_idle;
	bit want_hold, hold_done;
	bit loaded [65536];
	int words_sent;

	// current settings, mirrored for stimulus
	int cur_ox, cur_oz, cur_cols, cur_rows;
	longint cur_span;

	tile_height_ramp_sampler dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
	);

	tile_height_ramp_sampler_check checker_i (
		.clk, .arst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
		.failures, .pending, .checked, .ramp_results
	);

	// clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (want_hold && !hold_done) begin
				out_stall <= 1'b1;
				repeat (600) @(negedge clk);
				hold_done = 1'b1;
			end
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// run limit
	initial begin
		#15ms;
		$display("[tile_height_ramp_sampler] ERROR");
		$finish;
	end

	// fully random input word
	function automatic in_word_t rand_word();
		logic [255:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom};
		return in_word_t'(raw[$bits(in_word_t)-1:0]);
	endfunction

	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		words_sent++;
		if (w.kind == KIND_CELL)
			loaded[w.cell_index] = 1'b1;
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// let the block drain before touching registers
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic apply_settings(input int ox, oz, cols, rows, input longint sp,
			input int ramps);
		wait_drained();
		reg_write(REG_ORIGIN_X, 32'(ox));
		reg_write(REG_ORIGIN_Z, 32'(oz));
		reg_write(REG_COLUMNS, 32'(cols));
		reg_write(REG_ROWS, 32'(rows));
		reg_write(REG_SPAN, 32'(sp));
		reg_write(REG_RAMPS, 32'(ramps));
		cur_ox = ox;
		cur_oz = oz;
		cur_cols = cols;
		cur_rows = rows;
		cur_span = (sp == 0) ? 65536 : sp;
	endtask

	// fill every cell a query may read
	task automatic fill_grid();
		in_word_t w;
		for (int i = 0; i < cur_cols * cur_rows && i < 65536; i++) begin
			if (!loaded[i]) begin
				w = rand_word();
				w.kind = KIND_CELL;
				w.cell_index = 16'(i);
				send_word(w);
			end
		end
	endtask

	// world coordinate mostly within the grid, sometimes just outside it
	function automatic logic signed [31:0] pick_coord(input int org, input int tiles);
		longint tile, v;
		tile = $urandom_range(0, (tiles > 0) ? tiles - 1 : 0);
		if ($urandom_range(9) == 0)
			tile = ($urandom_range(1)) ? -1 : tiles;
		v = (org + tile) * cur_span + longint'($urandom_range(0, 32'(cur_span - 1)));
		if ($urandom_range(9) == 0)
			v = (org + tile) * cur_span;
		if (v < -64'sd2147483648 || v > 64'sd2147483647)
			return $urandom;
		return 32'(v);
	endfunction

	function automatic in_word_t make_query();
		in_word_t w;
		w = rand_word();
		w.kind = KIND_QUERY;
		if ($urandom_range(9) != 0) begin
			w.query_x = pick_coord(cur_ox, cur_cols);
			w.query_z = pick_coord(cur_oz, cur_rows);
		end
		return w;
	endfunction

	function automatic in_word_t make_ramp(input int slot);
		in_word_t w;
		w = rand_word();
		w.kind = KIND_RAMP;
		w.ramp_slot = 4'(slot);
		if ($urandom_range(7) != 0) begin
			w.ramp_col = 16'(cur_ox + $urandom_range(0, (cur_cols > 0) ? cur_cols - 1 : 0));
			w.ramp_row = 16'(cur_oz + $urandom_range(0, (cur_rows > 0) ? cur_rows - 1 : 0));
		end
		return w;
	endfunction

	// random mix of queries and loads under the current settings
	task automatic random_words(input int n);
		in_word_t w;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 62) begin
				w = make_query();
			end else if (pick < 78) begin
				w = rand_word();
				w.kind = KIND_CELL;
				if ($urandom_range(1) && cur_cols * cur_rows > 0)
					w.cell_index = 16'($urandom_range(0, cur_cols * cur_rows - 1));
			end else if (pick < 95) begin
				w = make_ramp($urandom_range(15));
			end else begin
				w = rand_word();
				w.kind = KIND_NONE;
			end
			send_word(w);
		end
	endtask

	// directed opening, then phases over several settings
	initial begin
		in_word_t w;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		want_hold = 1'b0;
		hold_done = 1'b0;
		words_sent = 0;
		send_idle = 34;
		recv_idle = 79;
		cur_ox = 0;
		cur_oz = 0;
		cur_cols = 0;
		cur_rows = 0;
		cur_span = 65536;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty grid straight after reset
		w = make_query();
		send_word(w);

		apply_settings(0, 0, 4, 4, 65536, 16);
		fill_grid();
		// every slot loaded, each heading, extreme heights
		for (int s = 0; s < 16; s++) begin
			w = make_ramp(s);
			w.ramp_col = 16'(s % 4);
			w.ramp_row = 16'(1 + s / 8);
			w.ramp_heading = 2'(s);
			if (s == 0) begin
				w.ramp_bottom = 32'sh7fffffff;
				w.ramp_top = 32'sh80000000;
			end
			send_word(w);
		end
		// query each ramp tile of row 1, first match wins for the shared tiles
		for (int c = 0; c < 4; c++) begin
			w = make_query();
			w.query_x = 32'(c * 65536 + $urandom_range(65535));
			w.query_z = 32'(65536 + $urandom_range(65535));
			send_word(w);
		end
		w = make_query();
		w.query_x = 32'sh7fffffff;
		w.query_z = 32'sh80000000;
		send_word(w);
		w.kind = KIND_NONE;
		send_word(w);
		random_words(40);

		apply_settings(-32768, 32767, 256, 1, 1, 20);
		fill_grid();
		random_words(25);

		send_idle = 79;
		recv_idle = 34;
		apply_settings(32767, -32768, 2, 128, 0, 3);
		fill_grid();
		random_words(25);

		apply_settings(-5, 7, 9, 6, 2147483647, 0);
		fill_grid();
		random_words(25);

		send_idle = 0;
		recv_idle = 0;
		apply_settings(3, -2, 16, 16, 12345, 8);
		fill_grid();
		want_hold = 1'b1;
		random_words(30);

		apply_settings(100, -100, 7, 3, 40000, 16);
		fill_grid();
		random_words(25);

		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (250) @(negedge clk);
		$display("run covered %0d input words over six settings", words_sent);
		$display("%0d heights checked, %0d of them from ramps", checked, ramp_results);
		if (failures == 0 && pending == 0) begin
			$display("[tile_height_ramp_sampler] OK");
		end else begin
			$display("[tile_height_ramp_sampler] ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/thrs_pkg.sv
sv/thrs_regs.sv
sv/thrs_divider.sv
sv/thrs_core.sv
sv/tile_height_ramp_sampler.sv
tb/tile_height_ramp_sampler_check.sv
tb/tile_height_ramp_sampler_test.sv
